/* hdl/cbaoc_pkg.sv */
package cbaoc_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        RK_EVICT  = 2'd0,
        RK_ADD    = 2'd1,
        RK_LOOKUP = 2'd2,
        RK_CLEAR  = 2'd3
    } result_kind_t;

    localparam int KEY_W   = 16;
    localparam int COST_W  = 31;
    localparam int STAMP_W = 32;
    localparam int TOTAL_W = 36;
    localparam int SUM_W   = 37;
    localparam int CNT_W   = 6;
    localparam logic [TOTAL_W-1:0] BUDGET_RESET = 36'd67108864;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};

    // One request as it waits between the front and the back part.
    typedef struct packed {
        opcode_t             op;
        logic [KEY_W-1:0]    key;
        logic [COST_W-1:0]   cost;
        logic [STAMP_W-1:0]  stamp;
    } request_t;

    // One result on its way to the output channel.
    typedef struct packed {
        result_kind_t        kind;
        logic [KEY_W-1:0]    key;
        logic [COST_W-1:0]   cost;
        logic                hit;
        logic                full_error;
        logic [TOTAL_W-1:0]  total;
        logic [CNT_W-1:0]    count;
        logic                last;
    } result_t;

endpackage

/* hdl/cbaoc_front.sv */
module cbaoc_front #(
    parameter int KEY_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cbaoc_pkg::request_t in_req,
    output logic                q_valid,
    input  logic                q_ready,
    output cbaoc_pkg::request_t q_req
);
    // Two-entry queue; unused opcodes and high key bits are dropped on entry.
    cbaoc_pkg::request_t slot_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          fill_reg;
    cbaoc_pkg::request_t clean;
    logic                push, pop;

    always_comb begin
        clean = in_req;
        clean.key = in_req.key & cbaoc_pkg::KEY_W'((64'd1 << KEY_BITS) - 64'd1);
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_req.op != cbaoc_pkg::OP_NONE);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= clean;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg != 2'd3)
        else $error("queue fill out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd2) |-> !push)
        else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (q_req.op != cbaoc_pkg::OP_NONE))
        else $error("unused opcode queued");
endmodule

/* hdl/cbaoc_back.sv */
module cbaoc_back #(
    parameter int CAPACITY = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cbaoc_pkg::TOTAL_W-1:0]  cost_budget,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  cbaoc_pkg::request_t            q_req,
    output logic                           r_valid,
    input  logic                           r_ready,
    output cbaoc_pkg::result_t             r_res
);
    localparam int IW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MATCH, S_REMOVE, S_INSERT, S_EVICT, S_DONE
    } state_t;

    // Cell chain: each cell holds one entry; shifts move whole rows at once.
    logic [cbaoc_pkg::KEY_W-1:0]   key_reg   [CAPACITY];
    logic [cbaoc_pkg::COST_W-1:0]  cost_reg  [CAPACITY];
    logic [cbaoc_pkg::STAMP_W-1:0] stamp_reg [CAPACITY];

    state_t                        state_reg;
    cbaoc_pkg::request_t           req_reg;
    logic [HW-1:0]                 held_reg;
    logic [cbaoc_pkg::SUM_W-1:0]   sum_reg;
    logic                          found_reg;
    logic                          full_reg;
    logic [IW-1:0]                 pos_reg;
    logic                          r_valid_reg;
    cbaoc_pkg::result_t            r_res_reg;

    logic [CAPACITY-1:0] match_vec, later_vec;
    logic                any_match;
    logic [IW-1:0]       match_pos, ins_pos;
    logic                r_free;
    logic                evict_now;
    logic                r_load;
    logic [cbaoc_pkg::TOTAL_W-1:0] total_now;

    always_comb begin
        match_vec = '0;
        later_vec = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (HW'(i) < held_reg) begin
                match_vec[i] = (key_reg[i] == req_reg.key);
                later_vec[i] = (stamp_reg[i] > req_reg.stamp);
            end
        end
        any_match = |match_vec;
        match_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match_vec[i]) match_pos = IW'(i);
        end
        ins_pos = IW'(held_reg);
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (later_vec[i]) ins_pos = IW'(i);
        end
    end

    assign total_now = (sum_reg > cbaoc_pkg::SUM_W'(cbaoc_pkg::TOTAL_SAT))
                     ? cbaoc_pkg::TOTAL_SAT : sum_reg[cbaoc_pkg::TOTAL_W-1:0];
    assign r_free    = !r_valid_reg || r_ready;
    assign evict_now = (sum_reg > cbaoc_pkg::SUM_W'(cost_budget)) && (held_reg > HW'(1));
    assign r_load    = r_free && ((state_reg == S_EVICT && evict_now) || state_reg == S_DONE);
    assign q_ready   = (state_reg == S_IDLE);
    assign r_valid   = r_valid_reg;
    assign r_res     = r_res_reg;

    // Cell rows: removal shifts down from pos, eviction shifts all down from cell 0, insertion shifts up from pos.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            priority if (state_reg == S_REMOVE && IW'(i) >= pos_reg && i < CAPACITY - 1) begin
                key_reg[i]   <= key_reg[i+1];
                cost_reg[i]  <= cost_reg[i+1];
                stamp_reg[i] <= stamp_reg[i+1];
            end else if (state_reg == S_EVICT && r_free && evict_now && i < CAPACITY - 1) begin
                key_reg[i]   <= key_reg[i+1];
                cost_reg[i]  <= cost_reg[i+1];
                stamp_reg[i] <= stamp_reg[i+1];
            end else if (state_reg == S_INSERT && IW'(i) == ins_pos) begin
                key_reg[i]   <= req_reg.key;
                cost_reg[i]  <= req_reg.cost;
                stamp_reg[i] <= req_reg.stamp;
            end else if (state_reg == S_INSERT && IW'(i) > ins_pos && i > 0) begin
                key_reg[i]   <= key_reg[i-1];
                cost_reg[i]  <= cost_reg[i-1];
                stamp_reg[i] <= stamp_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            sum_reg     <= '0;
            r_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            full_reg    <= 1'b0;
        end else begin
            if (r_load) begin
                r_valid_reg <= 1'b1;
            end else if (r_ready) begin
                r_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg   <= q_req;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    found_reg <= any_match;
                    pos_reg   <= match_pos;
                    full_reg  <= (req_reg.op == cbaoc_pkg::OP_ADD) && !any_match
                                 && (held_reg >= HW'(CAPACITY));
                    priority if (req_reg.op == cbaoc_pkg::OP_CLEAR) begin
                        held_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_DONE;
                    end else if (req_reg.op == cbaoc_pkg::OP_LOOKUP) begin
                        state_reg <= S_DONE;
                    end else if (any_match) begin
                        state_reg <= S_REMOVE;
                    end else if (held_reg >= HW'(CAPACITY)) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_INSERT;
                    end
                end
                S_REMOVE: begin
                    sum_reg   <= sum_reg - cbaoc_pkg::SUM_W'(cost_reg[pos_reg]);
                    held_reg  <= held_reg - HW'(1);
                    state_reg <= S_INSERT;
                end
                S_INSERT: begin
                    sum_reg   <= sum_reg + cbaoc_pkg::SUM_W'(req_reg.cost);
                    held_reg  <= held_reg + HW'(1);
                    state_reg <= S_EVICT;
                end
                S_EVICT: begin
                    if (r_free) begin
                        if (evict_now) begin
                            sum_reg     <= sum_reg - cbaoc_pkg::SUM_W'(cost_reg[0]);
                            held_reg    <= held_reg - HW'(1);
                            r_res_reg.kind <= cbaoc_pkg::RK_EVICT;
                            r_res_reg.key  <= key_reg[0];
                            r_res_reg.cost <= cost_reg[0];
                            r_res_reg.hit  <= 1'b0;
                            r_res_reg.full_error <= 1'b0;
                            r_res_reg.total <= (sum_reg - cbaoc_pkg::SUM_W'(cost_reg[0]))
                                > cbaoc_pkg::SUM_W'(cbaoc_pkg::TOTAL_SAT) ? cbaoc_pkg::TOTAL_SAT
                                : cbaoc_pkg::TOTAL_W'(sum_reg - cbaoc_pkg::SUM_W'(cost_reg[0]));
                            r_res_reg.count <= cbaoc_pkg::CNT_W'(held_reg - HW'(1));
                            r_res_reg.last  <= 1'b0;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (r_free) begin
                        r_res_reg.key   <= req_reg.key;
                        r_res_reg.cost  <= '0;
                        r_res_reg.total <= total_now;
                        r_res_reg.count <= cbaoc_pkg::CNT_W'(held_reg);
                        r_res_reg.last  <= 1'b1;
                        r_res_reg.full_error <= full_reg;
                        r_res_reg.hit   <= (req_reg.op != cbaoc_pkg::OP_CLEAR) && found_reg;
                        unique case (req_reg.op)
                            cbaoc_pkg::OP_CLEAR:  r_res_reg.kind <= cbaoc_pkg::RK_CLEAR;
                            cbaoc_pkg::OP_LOOKUP: r_res_reg.kind <= cbaoc_pkg::RK_LOOKUP;
                            default:              r_res_reg.kind <= cbaoc_pkg::RK_ADD;
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) held_reg <= HW'(CAPACITY))
        else $error("entry count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (r_valid_reg && !r_ready) |=> $stable(r_res_reg))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT) |=> (held_reg != '0))
        else $error("insert left table empty");
endmodule

/* hdl/cost_bounded_age_ordered_cache_unit.sv */
// Channel   | Direction | tdata fields (low bit first)                  | tuser / tlast
// s_axis    | in        | opcode, item_key, item_cost, item_stamp       | -
// m_axis    | out       | entry_key, entry_cost, full_error, total_cost,| tuser: result_kind,
//           |           | entry_count                                   | hit; tlast: last
// cfg       | in        | cost budget (write enable + data)             | -
//
// A request waits in a two-entry front queue; the back part then takes it, matches its key
// and writes the status result. An add that is not refused for a full table also inserts
// the entry, after first removing a replaced key, and then checks the budget and evicts the
// entry in cell 0, one at a time, until the total fits or only one entry is left.
// Reset (aresetn low at a clock edge) empties the table and restores the default budget.
// A stalled output holds the back part in place; the queue still takes two more requests.
module cost_bounded_age_ordered_cache_unit #(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [35:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0], item_key[17:2], item_cost[48:18], item_stamp[80:49], zero pad
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_key[15:0], entry_cost[46:16], full_error[47], total_cost[83:48],
    // entry_count[89:84], zero pad
    output logic [95:0]  m_axis_tdata,
    // result_kind[1:0], hit[2]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    logic [cbaoc_pkg::TOTAL_W-1:0] budget_reg;
    cbaoc_pkg::request_t in_req, q_req;
    cbaoc_pkg::result_t  r_res;
    logic                q_valid, q_ready;

    // The user must write the budget register only while no request is in flight; the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= cbaoc_pkg::BUDGET_RESET;
        end else if (cfg_wr_en) begin
            budget_reg <= cfg_wr_data;
        end
    end

    assign in_req.op    = cbaoc_pkg::opcode_t'(s_axis_tdata[1:0]);
    assign in_req.key   = s_axis_tdata[17:2];
    assign in_req.cost  = s_axis_tdata[48:18];
    assign in_req.stamp = s_axis_tdata[80:49];

    cbaoc_front #(.KEY_BITS(KEY_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    cbaoc_back #(.CAPACITY(CAPACITY)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cost_budget(budget_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_res(r_res)
    );

    assign m_axis_tdata = {6'd0, r_res.count, r_res.total, r_res.full_error,
                           r_res.cost, r_res.key};
    assign m_axis_tuser = {r_res.hit, r_res.kind};
    assign m_axis_tlast = r_res.last;
endmodule

/* sim/cost_bounded_age_ordered_cache_checker.sv */
module cost_bounded_age_ordered_cache_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [35:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending_results
);

    localparam int DEPTH = 32;

    logic [cbaoc_pkg::KEY_W-1:0]   tbl_key   [DEPTH];
    logic [cbaoc_pkg::COST_W-1:0]  tbl_cost  [DEPTH];
    logic [cbaoc_pkg::STAMP_W-1:0] tbl_stamp [DEPTH];
    int                            held;
    logic [cbaoc_pkg::SUM_W-1:0]   sum;
    logic [cbaoc_pkg::TOTAL_W-1:0] budget;
    cbaoc_pkg::result_t            awaited [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic cbaoc_pkg::request_t unpack_request(input logic [87:0] d);
        cbaoc_pkg::request_t r;
        r.op = cbaoc_pkg::opcode_t'(d[1:0]);
        r.key = d[17:2];
        r.cost = d[48:18];
        r.stamp = d[80:49];
        return r;
    endfunction

    function automatic cbaoc_pkg::result_t make_result(cbaoc_pkg::result_kind_t k,
                                            logic [cbaoc_pkg::KEY_W-1:0] key,
                                            logic [cbaoc_pkg::COST_W-1:0] cost, logic hit,
                                            logic full, logic last);
        cbaoc_pkg::result_t r;
        r.kind = k;
        r.key = key;
        r.cost = cost;
        r.hit = hit;
        r.full_error = full;
        r.total = (sum > {1'b0, cbaoc_pkg::TOTAL_SAT}) ? cbaoc_pkg::TOTAL_SAT
                                                      : sum[cbaoc_pkg::TOTAL_W-1:0];
        r.count = held[cbaoc_pkg::CNT_W-1:0];
        r.last = last;
        return r;
    endfunction

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < held; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_cost[i] = tbl_cost[i+1];
            tbl_stamp[i] = tbl_stamp[i+1];
        end
        held--;
    endtask

    // Apply one request to the shadow table and queue what it should produce.
    task automatic apply_request(input cbaoc_pkg::request_t rq);
        int pos;
        logic found;
        pos = 0;
        found = 1'b0;
        if (rq.op == cbaoc_pkg::OP_CLEAR) begin
            held = 0;
            sum = '0;
            awaited.push_back(make_result(cbaoc_pkg::RK_CLEAR, rq.key, '0, 1'b0, 1'b0, 1'b1));
        end else if (rq.op != cbaoc_pkg::OP_NONE) begin
            for (int i = 0; i < held; i++) begin
                if (!found && tbl_key[i] == rq.key) begin
                    found = 1'b1;
                    pos = i;
                end
            end
            if (rq.op == cbaoc_pkg::OP_LOOKUP) begin
                awaited.push_back(make_result(cbaoc_pkg::RK_LOOKUP, rq.key, '0, found,
                                              1'b0, 1'b1));
            end else if (!found && held >= DEPTH) begin
                awaited.push_back(make_result(cbaoc_pkg::RK_ADD, rq.key, '0, 1'b0, 1'b1, 1'b1));
            end else begin
                if (found) begin
                    sum = sum - tbl_cost[pos];
                    drop_entry(pos);
                end
                sum = sum + rq.cost;
                pos = held;
                for (int i = held - 1; i >= 0; i--) begin
                    if (tbl_stamp[i] > rq.stamp) pos = i;
                end
                for (int i = held; i > pos; i--) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_cost[i] = tbl_cost[i-1];
                    tbl_stamp[i] = tbl_stamp[i-1];
                end
                tbl_key[pos] = rq.key;
                tbl_cost[pos] = rq.cost;
                tbl_stamp[pos] = rq.stamp;
                held++;
                while (sum > {1'b0, budget} && held > 1) begin
                    logic [cbaoc_pkg::KEY_W-1:0] ek;
                    logic [cbaoc_pkg::COST_W-1:0] ec;
                    ek = tbl_key[0];
                    ec = tbl_cost[0];
                    sum = sum - ec;
                    drop_entry(0);
                    awaited.push_back(make_result(cbaoc_pkg::RK_EVICT, ek, ec, 1'b0, 1'b0, 1'b0));
                end
                awaited.push_back(make_result(cbaoc_pkg::RK_ADD, rq.key, '0, found, 1'b0, 1'b1));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held = 0;
            sum = '0;
            budget = cbaoc_pkg::BUDGET_RESET;
            awaited.delete();
        end else begin
            if (cfg_wr_en) budget = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) apply_request(unpack_request(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited.size() == 0) begin
                    report("unexpected result", m_axis_tdata[63:0], 64'd0);
                end else begin
                    cbaoc_pkg::result_t w;
                    w = awaited.pop_front();
                    if (m_axis_tuser[1:0] != w.kind)
                        report("kind", 64'(m_axis_tuser[1:0]), 64'(w.kind));
                    if (m_axis_tdata[15:0] != w.key)
                        report("key", 64'(m_axis_tdata[15:0]), 64'(w.key));
                    if (m_axis_tdata[46:16] != w.cost)
                        report("cost", 64'(m_axis_tdata[46:16]), 64'(w.cost));
                    if (m_axis_tuser[2] != w.hit)
                        report("hit", 64'(m_axis_tuser[2]), 64'(w.hit));
                    if (m_axis_tdata[47] != w.full_error)
                        report("full_error", 64'(m_axis_tdata[47]), 64'(w.full_error));
                    if (m_axis_tdata[83:48] != w.total)
                        report("total_cost", 64'(m_axis_tdata[83:48]), 64'(w.total));
                    if (m_axis_tdata[89:84] != w.count)
                        report("entry_count", 64'(m_axis_tdata[89:84]), 64'(w.count));
                    if (m_axis_tlast != w.last)
                        report("last", 64'(m_axis_tlast), 64'(w.last));
                end
            end
        end
        pending_results = awaited.size();
    end

    initial begin
        fail_count = 0;
        pending_results = 0;
    end

endmodule

/* sim/cost_bounded_age_ordered_cache_unit_tb.sv */
// Drives requests into the cache unit and lets the checker predict and compare.
// The run walks through a short directed list, then several phases of random
// traffic, each phase under its own cost budget. The budget is only rewritten
// once every expected result has come back and the unit has had time to settle.
module cost_bounded_age_ordered_cache_unit_tb;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [35:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending_results;
    int           cycle_count;
    bit           quiet_tail;

    cost_bounded_age_ordered_cache_unit uut (.*);

    cost_bounded_age_ordered_cache_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Generous bound: every request could drain the whole table while the
    // output side stalls for its longest burst on each result.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side stalls in random bursts, except in the final quiet stretch.
    initial begin
        int gap;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 17);
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge aclk);
                m_axis_tready = 1'b1;
            end
        end
    end

    // Present one request and hold it until the unit takes it. A random
    // idle burst may come first so that gaps land on every phase. The ready
    // seen at a falling edge is the one the next rising edge acts on.
    task automatic send_request(input cbaoc_pkg::opcode_t op, input logic [15:0] key,
                                input logic [30:0] cost, input logic [31:0] stamp);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_axis_tdata = {7'd0, stamp, cost, key, op};
        s_axis_tvalid = 1'b1;
        while (!s_axis_tready) @(negedge aclk);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait for every expected result, then for the unit to go quiet, and
    // only then write a new budget.
    task automatic set_budget(input logic [35:0] value);
        while (pending_results != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_wr_data = value;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Random traffic: mostly adds over a small key set so replacements,
    // evictions and a full table all happen; a few lookups, clears and
    // unused opcodes mixed in.
    task automatic random_phase(input int count, input int key_span, input int cost_max);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                send_request(cbaoc_pkg::OP_ADD, 16'($urandom_range(0, key_span)),
                             31'($urandom_range(0, cost_max)),
                             32'($urandom_range(0, 64) << 26));
            else if (sel < 88)
                send_request(cbaoc_pkg::OP_LOOKUP, 16'($urandom_range(0, key_span)),
                             31'($urandom), $urandom);
            else if (sel < 93)
                send_request(cbaoc_pkg::OP_CLEAR, 16'($urandom), 31'($urandom), $urandom);
            else if (sel < 96)
                send_request(cbaoc_pkg::OP_NONE, 16'($urandom), 31'($urandom), $urandom);
            else
                send_request(cbaoc_pkg::OP_ADD, 16'($urandom), 31'($urandom), $urandom);
        end
    endtask

    initial begin
        cycle_count = 0;
        quiet_tail = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: extremes of every field, each operation, and the
        // special cases under the reset budget.
        send_request(cbaoc_pkg::OP_LOOKUP, 16'h0000, '0, '0);
        send_request(cbaoc_pkg::OP_ADD, 16'hFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
        send_request(cbaoc_pkg::OP_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
        send_request(cbaoc_pkg::OP_ADD, 16'h0000, 31'd0, 32'd0);
        send_request(cbaoc_pkg::OP_ADD, 16'h0001, 31'd100, 32'd0);  // equal stamp goes after
        send_request(cbaoc_pkg::OP_ADD, 16'hFFFF, 31'd5, 32'd7);    // replace an entry
        send_request(cbaoc_pkg::OP_NONE, 16'h1234, 31'd9, 32'd9);   // unused opcode, no result
        send_request(cbaoc_pkg::OP_CLEAR, 16'hA5A5, '0, '0);

        // Fill the table to capacity with a huge budget, then overflow it.
        set_budget(36'hFFFFFFFFF);
        for (int i = 0; i < 32; i++) send_request(cbaoc_pkg::OP_ADD, i[15:0], 31'd1, i[31:0]);
        send_request(cbaoc_pkg::OP_ADD, 16'h0100, 31'd1, 32'd3);    // dropped: table full
        send_request(cbaoc_pkg::OP_ADD, 16'h0005, 31'd2, 32'd99);   // replace while full
        send_request(cbaoc_pkg::OP_LOOKUP, 16'h0005, '0, '0);

        // Zero budget: the table is still full, so both new keys are refused
        // with a full error and nothing is evicted.
        set_budget(36'd0);
        send_request(cbaoc_pkg::OP_ADD, 16'h0200, 31'd50, 32'd1);
        send_request(cbaoc_pkg::OP_ADD, 16'h0201, 31'd60, 32'd2);

        set_budget(36'd67108864);
        random_phase(55, 40, 31'h00FFFFFF);
        set_budget(36'd0);
        random_phase(25, 15, 31'h7FFFFFFF);
        set_budget(36'hFFFFFFFFF);
        random_phase(55, 40, 31'h7FFFFFFF);
        set_budget(36'($urandom_range(0, 32'h7FFFFFFF)));
        quiet_tail = 1'b1;
        random_phase(40, 20, 31'h1FFFFFFF);

        while (pending_results != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
